// File: rtl/core/calr_pkg.sv
`timescale 1ns / 1ps

package calr_pkg;

	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 4;
	localparam int DIST_BITS    = 18;
	localparam int SPACING_BITS = 16;

	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int MUL_DIGITS = (COORD_BITS + 1) / 2;
	localparam int MUL_W      = 2 * MUL_DIGITS;
	localparam int RAD_PAIRS  = (SQ_BITS + 1 + 2 * FRAC_BITS + 1) / 2;
	localparam int RAD_W      = 2 * RAD_PAIRS;
	localparam int ROOT_BITS  = RAD_PAIRS;
	localparam int REM_BITS   = ROOT_BITS + 2;
	localparam int CNT_BITS   = $clog2(RAD_PAIRS);

	localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(160);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [ROOT_BITS-1:0]  root_t;

	function automatic coord_t abs_diff(input coord_t a, input coord_t b);
		abs_diff = (a >= b) ? coord_t'(a - b) : coord_t'(b - a);
	endfunction

endpackage

// File: rtl/core/contour_arc_length_resampler_top.sv
`timescale 1ns / 1ps
// Contour arc-length resampler.
// Input beats arrive on s_axis: tdata carries point_x and point_y, tuser
// carries contour_start. Kept points leave on m_axis with the same layout.
// The user must write min_spacing through the cfg channel only while idle;
// the block does not enforce it. It takes effect on the next point.
// One point is worked on at a time. A contour-start point skips the step
// unit and is kept once the output register is free; input is then ready.
// Any other point goes through a 2-bit-digit serial squarer, a radicand
// load, a bit-pair serial square root (one root bit per radicand bit
// pair), a done hand-over and a final accumulate-and-compare step before
// the input is ready again.
// A kept point sits in the output register until m_axis_tready; the next
// point may be accepted and worked on meanwhile, and the block only waits
// if a second kept point is ready before the first has gone.
// Reset clears the previous point to (0,0), the running distance to zero,
// min_spacing to 160 and drops any pending output beat.
module contour_arc_length_resampler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [11:0] point_x, [23:12] point_y
	input  logic [0:0]  s_axis_tuser,   // [0] contour_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [11:0] out_x, [23:12] out_y
	output logic [0:0]  m_axis_tuser,   // [0] out_start
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import calr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_CALC   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                  state_q;
	logic [SPACING_BITS-1:0] spacing_q;
	coord_t                  prev_x_q;
	coord_t                  prev_y_q;
	logic [DIST_BITS-1:0]    dist_q;
	coord_t                  x_q;
	coord_t                  y_q;
	logic                    start_q;
	root_t                   step_q;
	logic                    out_valid_q;
	coord_t                  out_x_q;
	coord_t                  out_y_q;
	logic                    out_start_q;

	coord_t                  in_x;
	coord_t                  in_y;
	logic                    in_start;
	logic                    accept;
	logic                    go;
	logic                    su_done;
	root_t                   su_root;
	logic [DIST_BITS:0]      sum_w;
	logic [DIST_BITS-1:0]    sum_sat;
	logic                    keep;
	logic                    out_free;
	logic                    load_out;

	assign in_x     = s_axis_tdata[COORD_BITS-1:0];
	assign in_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_start = s_axis_tuser[0];

	assign s_axis_tready = state_q == ST_IDLE;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign go            = accept && !in_start;
	assign cfg_ready     = 1'b1;

	calr_step_unit u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.dx     (abs_diff(in_x, prev_x_q)),
		.dy     (abs_diff(in_y, prev_y_q)),
		.done   (su_done),
		.root   (su_root)
	);

	assign sum_w    = (DIST_BITS+1)'(dist_q) + (DIST_BITS+1)'(step_q);
	assign sum_sat  = sum_w[DIST_BITS] ? {DIST_BITS{1'b1}} : sum_w[DIST_BITS-1:0];
	assign keep     = start_q || (sum_sat >= DIST_BITS'(spacing_q));
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_out = (state_q == ST_FINISH) && keep && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			spacing_q   <= SPACING_RESET;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			dist_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				spacing_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_x_q <= in_x;
						prev_y_q <= in_y;
						state_q  <= in_start ? ST_FINISH : ST_CALC;
					end
				end
				ST_CALC: begin
					if (su_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!keep) begin
						dist_q  <= sum_sat;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						dist_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= in_x;
			y_q     <= in_y;
			start_q <= in_start;
			step_q  <= '0;
		end else if (state_q == ST_CALC && su_done) begin
			step_q <= su_root;
		end
		if (load_out) begin
			out_x_q     <= x_q;
			out_y_q     <= y_q;
			out_start_q <= start_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_y_q, out_x_q};
	assign m_axis_tuser[0] = out_start_q;

endmodule

// File: rtl/core/calr_step_unit.sv
`timescale 1ns / 1ps

module calr_step_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  calr_pkg::coord_t dx,
	input  calr_pkg::coord_t dy,
	output logic            done,
	output calr_pkg::root_t root
);
	import calr_pkg::*;

	typedef enum logic [3:0] {
		SU_IDLE = 4'b0001,
		SU_MUL  = 4'b0010,
		SU_LOAD = 4'b0100,
		SU_SQRT = 4'b1000
	} su_state_t;

	su_state_t              state_q;
	logic [CNT_BITS-1:0]    cnt_q;
	coord_t                 dx_q;
	coord_t                 dy_q;
	logic [MUL_W-1:0]       mx_q;
	logic [MUL_W-1:0]       my_q;
	logic [SQ_BITS-1:0]     accx_q;
	logic [SQ_BITS-1:0]     accy_q;
	logic [RAD_W-1:0]       rad_q;
	logic [REM_BITS-1:0]    rem_q;
	root_t                  root_q;
	logic                   done_q;

	logic [COORD_BITS+1:0]  termx;
	logic [COORD_BITS+1:0]  termy;
	logic [SQ_BITS:0]       sq_sum;
	logic [REM_BITS-1:0]    rem_sh;
	logic [REM_BITS-1:0]    trial;
	logic                   fits;

	function automatic logic [COORD_BITS+1:0] digit_mul(input coord_t a, input logic [1:0] d);
		logic [COORD_BITS+1:0] a1;
		logic [COORD_BITS+1:0] a2;
		a1 = (COORD_BITS+2)'(a);
		a2 = (COORD_BITS+2)'({a, 1'b0});
		case (d)
			2'd0:    digit_mul = '0;
			2'd1:    digit_mul = a1;
			2'd2:    digit_mul = a2;
			2'd3:    digit_mul = a1 + a2;
			default: digit_mul = '0;
		endcase
	endfunction

	assign termx  = digit_mul(dx_q, mx_q[MUL_W-1 -: 2]);
	assign termy  = digit_mul(dy_q, my_q[MUL_W-1 -: 2]);
	assign sq_sum = (SQ_BITS+1)'(accx_q) + (SQ_BITS+1)'(accy_q);
	assign rem_sh = {rem_q[REM_BITS-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SU_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SU_IDLE: begin
					if (go) begin
						cnt_q   <= '0;
						state_q <= SU_MUL;
					end
				end
				SU_MUL: begin
					if (cnt_q == CNT_BITS'(MUL_DIGITS - 1)) begin
						state_q <= SU_LOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				SU_LOAD: begin
					cnt_q   <= '0;
					state_q <= SU_SQRT;
				end
				SU_SQRT: begin
					if (cnt_q == CNT_BITS'(RAD_PAIRS - 1)) begin
						done_q  <= 1'b1;
						state_q <= SU_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= SU_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SU_IDLE: begin
				if (go) begin
					dx_q   <= dx;
					dy_q   <= dy;
					mx_q   <= MUL_W'(dx);
					my_q   <= MUL_W'(dy);
					accx_q <= '0;
					accy_q <= '0;
				end
			end
			SU_MUL: begin
				accx_q <= {accx_q[SQ_BITS-3:0], 2'b00} + SQ_BITS'(termx);
				accy_q <= {accy_q[SQ_BITS-3:0], 2'b00} + SQ_BITS'(termy);
				mx_q   <= {mx_q[MUL_W-3:0], 2'b00};
				my_q   <= {my_q[MUL_W-3:0], 2'b00};
			end
			SU_LOAD: begin
				rad_q  <= RAD_W'(sq_sum) << (2 * FRAC_BITS);
				rem_q  <= '0;
				root_q <= '0;
			end
			SU_SQRT: begin
				rad_q <= {rad_q[RAD_W-3:0], 2'b00};
				if (fits) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule
